### sv/paged_framebuffer_pixel_rmw_assert.svh
// ============================================================================
// Paged framebuffer pixel RMW - assertion macros
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ============================================================================
`ifndef PAGED_FRAMEBUFFER_PIXEL_RMW_ASSERT_SVH
`define PAGED_FRAMEBUFFER_PIXEL_RMW_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication, disabled while reset is asserted
`define PFB_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pfb assertion failed");

// next-cycle implication, disabled while reset is asserted
`define PFB_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pfb assertion failed");

`else

`define PFB_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define PFB_ASSERT_NXT(name, clk, rst_n, ante, cons)

`endif

`endif

### sv/pfb_pkg.sv
// ============================================================================
// Paged framebuffer pixel RMW - package
// Geometry defaults, operation codes and the command / result word types.
// ============================================================================
package pfb_pkg;

    // default frame geometry
    localparam int C_COLUMNS       = 84;
    localparam int C_PAGES         = 6;
    localparam int C_BITS_PER_BYTE = 8;

    // fixed field widths
    localparam int C_INDEX_W    = 12;
    localparam int C_PAGE_ROW_W = 3;
    localparam int C_COLUMN_W   = 7;
    localparam int C_BYTE_W     = 8;

    // extra fraction bits of the divide-by-columns reciprocal
    localparam int C_RECIP_GUARD = 8;

    // pixel operations
    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_SET    = 2'd1,
        OP_TOGGLE = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    // command word
    typedef struct packed {
        t_op                  op;
        logic [C_INDEX_W-1:0] pixel_index;
    } t_pix_cmd;

    // result word
    typedef struct packed {
        logic [C_PAGE_ROW_W-1:0] page_row;
        logic [C_COLUMN_W-1:0]   column;
        logic [C_BYTE_W-1:0]     byte_value;
        logic                    pixel_value;
        logic                    index_error;
    } t_pix_result;

endpackage

### sv/paged_framebuffer_pixel_rmw.sv
// Pipeline: a command passes the input, s2, s3, s4 and result registers.
// Throughput: one command per cycle while busy is low; back-to-back hits on
// the same byte are forwarded from the write-back register around the frame
// memory. Reset: synchronous, active low; the frame memory is then zeroed
// one byte a cycle, all PAGES*COLUMNS bytes (504 by default), with busy high
// throughout. Results cannot be stalled by the receiver.
// ============================================================================
// Paged framebuffer pixel RMW
// Splits a linear pixel index into page, column and bit, then read-modify-
// writes one byte of a page-organised monochrome frame memory.
// ============================================================================
`include "paged_framebuffer_pixel_rmw_assert.svh"

module paged_framebuffer_pixel_rmw
    import pfb_pkg::*;
#(
    parameter int COLUMNS = C_COLUMNS,
    parameter int PAGES   = C_PAGES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    input  t_pix_cmd    i_cmd,
    output logic        busy,
    output logic        o_valid,
    output t_pix_result o_result
);

    localparam int STORE_BYTES  = PAGES * COLUMNS;
    localparam int FRAME_PIXELS = STORE_BYTES * C_BITS_PER_BYTE;
    localparam int ADDR_W       = $clog2(STORE_BYTES);
    localparam int COL_W        = $clog2(COLUMNS);
    localparam int BIT_W        = $clog2(C_BITS_PER_BYTE);
    localparam int Q_W          = C_INDEX_W - COL_W + 1;
    localparam int PAGE_W       = Q_W - BIT_W;
    localparam int RECIP_SHIFT  = C_INDEX_W + C_RECIP_GUARD;
    localparam int RECIP_W      = RECIP_SHIFT - COL_W + 1;
    localparam int PROD_W       = C_INDEX_W + RECIP_W;
    localparam int RECIP        = (2 ** RECIP_SHIFT + COLUMNS - 1) / COLUMNS;

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    logic                   w_accept;

    logic                   r_clr_busy;
    logic [ADDR_W-1:0]      r_clr_addr;

    logic                   r_in_valid;
    t_op                    r_in_op;
    logic [C_INDEX_W-1:0]   r_in_idx;

    logic [PROD_W-1:0]      w_prod;
    logic                   w_err;

    logic                   r_s2_valid;
    t_op                    r_s2_op;
    logic                   r_s2_err;
    logic [C_INDEX_W-1:0]   r_s2_idx;
    logic [Q_W-1:0]         r_s2_q;

    logic [C_INDEX_W-1:0]   w_qc;
    logic [ADDR_W-1:0]      w_pc;

    logic                   r_s3_valid;
    t_op                    r_s3_op;
    logic                   r_s3_err;
    logic [C_INDEX_W-1:0]   r_s3_idx;
    logic [C_INDEX_W-1:0]   r_s3_qc;
    logic [ADDR_W-1:0]      r_s3_pc;
    logic [PAGE_W-1:0]      r_s3_page;
    logic [BIT_W-1:0]       r_s3_bit;

    logic [C_INDEX_W-1:0]   w_diff;
    logic [COL_W-1:0]       w_col;
    logic [ADDR_W-1:0]      w_rd_addr;

    logic [C_BYTE_W-1:0]    r_mem [STORE_BYTES];
    logic [C_BYTE_W-1:0]    r_rd_data;

    logic                   r_s4_valid;
    t_op                    r_s4_op;
    logic                   r_s4_err;
    logic [ADDR_W-1:0]      r_s4_addr;
    logic [COL_W-1:0]       r_s4_col;
    logic [PAGE_W-1:0]      r_s4_page;
    logic [BIT_W-1:0]       r_s4_bit;

    logic [C_BYTE_W-1:0]    w_old;
    logic [C_BYTE_W-1:0]    w_mask;
    logic [C_BYTE_W-1:0]    w_new;
    logic                   w_we_pix;
    logic                   w_we;
    logic [ADDR_W-1:0]      w_wr_addr;
    logic [C_BYTE_W-1:0]    w_wr_data;

    logic                   r_wb_valid;
    logic [ADDR_W-1:0]      r_wb_addr;
    logic [C_BYTE_W-1:0]    r_wb_data;

    logic                   r_res_valid;
    t_pix_result            r_res;
    t_pix_result            n_res;

    assign w_accept = start && !busy;
    assign busy     = r_clr_busy;

    // ------------------------------------------------------------------
    // Clear pass after reset: zero the frame memory one byte a cycle
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == ADDR_W'(STORE_BYTES - 1)) begin
                r_clr_busy <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Pipeline valid bits
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_wb_valid  <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_in_valid  <= w_accept;
            r_s2_valid  <= r_in_valid;
            r_s3_valid  <= r_s2_valid;
            r_s4_valid  <= r_s3_valid;
            r_wb_valid  <= w_we_pix;
            r_res_valid <= r_s4_valid;
        end
    end

    // ------------------------------------------------------------------
    // Input register: capture the command word
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_op  <= i_cmd.op;
            r_in_idx <= i_cmd.pixel_index;
        end
    end

    // ------------------------------------------------------------------
    // Row = index / COLUMNS by reciprocal multiply; range check
    // ------------------------------------------------------------------
    assign w_prod = PROD_W'(r_in_idx) * PROD_W'(RECIP);
    assign w_err  = {{(32 - C_INDEX_W){1'b0}}, r_in_idx} >= 32'(FRAME_PIXELS);

    always_ff @(posedge i_clk) begin
        r_s2_op  <= r_in_op;
        r_s2_err <= w_err;
        r_s2_idx <= r_in_idx;
        r_s2_q   <= w_prod[RECIP_SHIFT +: Q_W];
    end

    // ------------------------------------------------------------------
    // Row * COLUMNS for the remainder, page * COLUMNS for the byte address
    // ------------------------------------------------------------------
    assign w_qc = C_INDEX_W'(r_s2_q) * C_INDEX_W'(COLUMNS);
    assign w_pc = ADDR_W'(r_s2_q[Q_W-1:BIT_W]) * ADDR_W'(COLUMNS);

    always_ff @(posedge i_clk) begin
        r_s3_op   <= r_s2_op;
        r_s3_err  <= r_s2_err;
        r_s3_idx  <= r_s2_idx;
        r_s3_qc   <= w_qc;
        r_s3_pc   <= w_pc;
        r_s3_page <= r_s2_q[Q_W-1:BIT_W];
        r_s3_bit  <= r_s2_q[BIT_W-1:0];
    end

    // ------------------------------------------------------------------
    // Column and byte address; issue the memory read
    // ------------------------------------------------------------------
    assign w_diff    = r_s3_idx - r_s3_qc;
    assign w_col     = w_diff[COL_W-1:0];
    assign w_rd_addr = r_s3_err ? '0 : r_s3_pc + ADDR_W'(w_col);

    always_ff @(posedge i_clk) begin
        if (r_s3_valid) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_s4_op   <= r_s3_op;
        r_s4_err  <= r_s3_err;
        r_s4_addr <= w_rd_addr;
        r_s4_col  <= w_col;
        r_s4_page <= r_s3_page;
        r_s4_bit  <= r_s3_bit;
    end

    // ------------------------------------------------------------------
    // Modify: forward the previous write on an address hit, apply the op
    // ------------------------------------------------------------------
    assign w_old  = (r_wb_valid && (r_wb_addr == r_s4_addr)) ? r_wb_data : r_rd_data;
    assign w_mask = C_BYTE_W'(1) << r_s4_bit;

    always_comb begin
        unique case (r_s4_op)
            OP_CLEAR:  w_new = w_old & ~w_mask;
            OP_SET:    w_new = w_old | w_mask;
            OP_TOGGLE: w_new = w_old ^ w_mask;
            OP_READ:   w_new = w_old;
            default:   w_new = w_old;
        endcase
    end

    assign w_we_pix = r_s4_valid && !r_s4_err && (r_s4_op != OP_READ);

    // ------------------------------------------------------------------
    // Write port: clear pass or pixel write-back
    // ------------------------------------------------------------------
    assign w_we      = r_clr_busy || w_we_pix;
    assign w_wr_addr = r_clr_busy ? r_clr_addr : r_s4_addr;
    assign w_wr_data = r_clr_busy ? '0 : w_new;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
    end

    // hold the last write for forwarding
    always_ff @(posedge i_clk) begin
        r_wb_addr <= r_s4_addr;
        r_wb_data <= w_new;
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_comb begin
        n_res = '0;
        if (r_s4_err) begin
            n_res.index_error = 1'b1;
        end else begin
            n_res.page_row    = C_PAGE_ROW_W'(r_s4_page);
            n_res.column      = C_COLUMN_W'(r_s4_col);
            n_res.byte_value  = w_new;
            n_res.pixel_value = |(w_new & w_mask);
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_valid  = r_res_valid;
    assign o_result = r_res;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `PFB_ASSERT_IMP(a_no_pix_write_in_clear, i_clk, i_rst_n, r_clr_busy, !w_we_pix)
    `PFB_ASSERT_IMP(a_error_zero_payload, i_clk, i_rst_n,
        o_valid && o_result.index_error,
        (o_result.page_row == '0) && (o_result.column == '0) &&
        (o_result.byte_value == '0) && !o_result.pixel_value)
    `PFB_ASSERT_IMP(a_result_latency, i_clk, i_rst_n,
        $past(w_accept, 5) && $past(i_rst_n, 1) && $past(i_rst_n, 2) &&
        $past(i_rst_n, 3) && $past(i_rst_n, 4) && $past(i_rst_n, 5),
        o_valid)
    `PFB_ASSERT_IMP(a_clear_covers_store, i_clk, i_rst_n, $fell(r_clr_busy),
        $past(r_clr_addr) == ADDR_W'(STORE_BYTES - 1))

endmodule

### tb/paged_framebuffer_pixel_rmw_tb.sv
// ============================================================================
// Paged framebuffer pixel RMW - testbench
// Drives pixel commands (clear, set, toggle, read) into the frame store and
// keeps a shadow copy of the frame to predict every result word. Directed
// words cover the frame corners, indexes past the frame and all operations
// on one byte. Random words follow, often on the byte just touched to
// exercise forwarding, with the sender idling at several rates.
// ============================================================================
module paged_framebuffer_pixel_rmw_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pfb_pkg::*;

    localparam int FRAME_BYTES  = C_PAGES * C_COLUMNS;
    localparam int FRAME_PIXELS = FRAME_BYTES * C_BITS_PER_BYTE;
    localparam int MAX_INDEX    = (1 << C_INDEX_W) - 1;
    localparam int RUN_LIMIT    = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_GAP      = 20;
    localparam int REPORT_LIMIT = 10;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start   = 1'b0;
    t_pix_cmd    i_cmd   = '0;
    logic        busy;
    logic        o_valid;
    t_pix_result o_result;

    // shadow frame and the results still owed by the block
    logic [C_BYTE_W-1:0] shadow_frame [FRAME_BYTES];
    t_pix_result         owed_results [$];
    int unsigned         mismatch_count  = 0;
    int unsigned         cycle_count     = 0;
    int                  sender_idle_pct = 0;
    int                  last_index      = 0;
    bit                  start_held      = 1'b0;

    paged_framebuffer_pixel_rmw u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // apply one pixel operation to the shadow frame, return the result word
    function automatic t_pix_result apply_pixel_op(t_op op, logic [C_INDEX_W-1:0] idx);
        int                  row;
        int                  col;
        int                  page;
        int                  bitpos;
        int                  addr;
        logic [C_BYTE_W-1:0] mask;
        logic [C_BYTE_W-1:0] val;
        t_pix_result         res;
        res = '0;
        if (int'(idx) >= FRAME_PIXELS) begin
            res.index_error = 1'b1;
            return res;
        end
        row    = int'(idx) / C_COLUMNS;
        col    = int'(idx) % C_COLUMNS;
        page   = row / C_BITS_PER_BYTE;
        bitpos = row % C_BITS_PER_BYTE;
        addr   = page * C_COLUMNS + col;
        mask   = 8'(1 << bitpos);
        val    = shadow_frame[addr];
        case (op)
            OP_CLEAR:  val = val & ~mask;
            OP_SET:    val = val | mask;
            OP_TOGGLE: val = val ^ mask;
            default:   val = val;
        endcase
        shadow_frame[addr] = val;
        res.page_row    = C_PAGE_ROW_W'(page);
        res.column      = C_COLUMN_W'(col);
        res.byte_value  = val;
        res.pixel_value = |(val & mask);
        return res;
    endfunction

    // hold the word on the inputs until accepted, then maybe idle
    task automatic send_pixel_cmd(input t_op op, input int idx);
        t_pix_cmd cmd;
        int       gap;
        cmd.op          = op;
        cmd.pixel_index = C_INDEX_W'(idx);
        start <= 1'b1;
        i_cmd <= cmd;
        do @(posedge i_clk); while (busy);
        owed_results.push_back(apply_pixel_op(op, cmd.pixel_index));
        last_index = idx;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
        if (gap > 0) begin
            start      <= 1'b0;
            start_held  = 1'b0;
            repeat (gap) @(posedge i_clk);
        end else begin
            start_held = 1'b1;
        end
    endtask

    // drop start, wait for every owed result, then let the pipeline drain
    task automatic wait_until_idle();
        if (start_held) begin
            start      <= 1'b0;
            start_held  = 1'b0;
        end
        do @(posedge i_clk); while (owed_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic note_mismatch(input string what, input t_pix_result want,
                                 input t_pix_result got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%t %s: expected page %0d col %0d byte %02h pix %0b err %0b, got page %0d col %0d byte %02h pix %0b err %0b",
                     $realtime, what, want.page_row, want.column, want.byte_value,
                     want.pixel_value, want.index_error, got.page_row, got.column,
                     got.byte_value, got.pixel_value, got.index_error);
    endtask

    // compare each result word with the oldest prediction
    always @(posedge i_clk) begin
        t_pix_result want;
        if (i_rst_n && o_valid) begin
            if (owed_results.size() == 0) begin
                note_mismatch("unexpected result", '0, o_result);
            end else begin
                want = owed_results.pop_front();
                if (want.page_row !== o_result.page_row ||
                    want.column !== o_result.column ||
                    want.byte_value !== o_result.byte_value ||
                    want.pixel_value !== o_result.pixel_value ||
                    want.index_error !== o_result.index_error)
                    note_mismatch("result mismatch", want, o_result);
            end
        end
    end

    // run limit
    initial begin
        while (cycle_count < RUN_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    // corners of the frame and the first bit of the second page
    task automatic test_frame_corners();
        send_pixel_cmd(OP_SET, 0);
        send_pixel_cmd(OP_SET, C_COLUMNS - 1);
        send_pixel_cmd(OP_SET, 7 * C_COLUMNS + C_COLUMNS - 1);
        send_pixel_cmd(OP_SET, FRAME_PIXELS - 1);
        send_pixel_cmd(OP_READ, FRAME_PIXELS - 1);
        send_pixel_cmd(OP_READ, 0);
        send_pixel_cmd(OP_TOGGLE, 8 * C_COLUMNS);
    endtask

    // indexes past the frame must flag an error and leave the store alone
    task automatic test_out_of_frame();
        send_pixel_cmd(OP_CLEAR, FRAME_PIXELS);
        send_pixel_cmd(OP_SET, MAX_INDEX);
        send_pixel_cmd(OP_TOGGLE, FRAME_PIXELS + 8);
        send_pixel_cmd(OP_READ, MAX_INDEX);
        send_pixel_cmd(OP_READ, FRAME_PIXELS - 1);
    endtask

    // every operation on the bits of one byte, mostly back to back
    task automatic test_one_byte_ops();
        int base;
        base = 2 * C_BITS_PER_BYTE * C_COLUMNS + 40;
        send_pixel_cmd(OP_SET, base + 3 * C_COLUMNS);
        send_pixel_cmd(OP_SET, base + 5 * C_COLUMNS);
        send_pixel_cmd(OP_TOGGLE, base + 3 * C_COLUMNS);
        send_pixel_cmd(OP_TOGGLE, base);
        send_pixel_cmd(OP_CLEAR, base + 5 * C_COLUMNS);
        send_pixel_cmd(OP_CLEAR, base + 5 * C_COLUMNS);
        send_pixel_cmd(OP_READ, base);
        // alternating index bit patterns
        send_pixel_cmd(OP_SET, 'hAAA);
        send_pixel_cmd(OP_TOGGLE, 'h555);
    endtask

    // random traffic, often on a bit of the byte just touched
    task automatic test_random_rmw(input int idle_pct, input int count);
        int sel;
        int idx;
        int row;
        sender_idle_pct = idle_pct;
        repeat (count) begin
            sel = $urandom_range(99);
            if (sel < 45 && last_index < FRAME_PIXELS) begin
                row = (last_index / C_COLUMNS / C_BITS_PER_BYTE) * C_BITS_PER_BYTE
                      + $urandom_range(C_BITS_PER_BYTE - 1);
                idx = row * C_COLUMNS + last_index % C_COLUMNS;
            end else if (sel < 90) begin
                idx = $urandom_range(FRAME_PIXELS - 1);
            end else begin
                idx = $urandom_range(MAX_INDEX);
            end
            send_pixel_cmd(t_op'($urandom_range(3)), idx);
        end
    endtask

    initial begin
        foreach (shadow_frame[i]) shadow_frame[i] = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        sender_idle_pct = 12;
        test_frame_corners();
        test_out_of_frame();
        test_one_byte_ops();
        test_random_rmw(12, 700);
        test_random_rmw(82, 700);
        test_random_rmw(0, 600);
        wait_until_idle();

        mismatch_count += owed_results.size();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
